// File: src/html_link_attribute_extractor_unit_macros.svh
// ----------------------------------------------------------------------------
// html link attribute extractor - assertion macros
// shared property wrappers, sampled on clk_i, off while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef HTML_LINK_ATTRIBUTE_EXTRACTOR_UNIT_MACROS_SVH
`define HTML_LINK_ATTRIBUTE_EXTRACTOR_UNIT_MACROS_SVH

// same-cycle implication
`define HLAE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HLAE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/hlae_pkg.sv
// ----------------------------------------------------------------------------
// hlae_pkg
// types, constants and helpers of the html link attribute extractor
// ----------------------------------------------------------------------------
`default_nettype none

package hlae_pkg;

  localparam int unsigned MAX_LINKS   = 512;
  localparam int unsigned LINK_BUFFER = 512;

  localparam int unsigned CNT_W      = $clog2(MAX_LINKS);
  localparam int unsigned LEN_W      = $clog2(LINK_BUFFER);
  localparam int unsigned LINK_NUM_W = 9;

  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;

  typedef enum logic [1:0] {
    KIND_CHAR    = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_DISCARD = 2'd2,
    KIND_DROP    = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0]            link_char;
    kind_e                 kind;
    logic [LINK_NUM_W-1:0] link_number;
    logic                  list_full;
  } result_t;

  function automatic logic [7:0] fold(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5a) begin
      return c + 8'd32;
    end
    return c;
  endfunction

  function automatic logic [7:0] word_h(input logic [1:0] p);
    logic [7:0] r;
    case (p)
      2'd0: r = "h";
      2'd1: r = "r";
      2'd2: r = "e";
      default: r = "f";
    endcase
    return r;
  endfunction

  function automatic logic [7:0] word_s(input logic [1:0] p);
    logic [7:0] r;
    case (p)
      2'd0: r = "s";
      2'd1: r = "r";
      2'd2: r = "c";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: src/hlae_in_if.sv
// ----------------------------------------------------------------------------
// hlae_in_if
// request channel: one document byte or an end-of-file mark
// ----------------------------------------------------------------------------
`default_nettype none

interface hlae_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_of_file;

  modport source (output valid, byte_in, end_of_file, input ready);
  modport sink (input valid, byte_in, end_of_file, output ready);
endinterface

`default_nettype wire

// File: src/hlae_out_if.sv
// ----------------------------------------------------------------------------
// hlae_out_if
// result channel: link character, completion, discard or drop
// ----------------------------------------------------------------------------
`default_nettype none

interface hlae_out_if;
  import hlae_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [7:0]            link_char;
  logic [1:0]            kind;
  logic [LINK_NUM_W-1:0] link_number;
  logic                  list_full;

  modport source (output valid, link_char, kind, link_number, list_full, input ready);
  modport sink (input valid, link_char, kind, link_number, list_full, output ready);
endinterface

`default_nettype wire

// File: src/hlae_front.sv
// ----------------------------------------------------------------------------
// hlae_front
// accepts bytes, runs the word match / quote / collect phases, pushes results
// ----------------------------------------------------------------------------
`default_nettype none

module hlae_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  hlae_in_if.sink                req_i,
  input  wire logic              q_full_i,
  output logic                   push_o,
  output hlae_pkg::result_t      res_o
);
  import hlae_pkg::*;

  localparam logic [1:0] PH_SEARCH  = 2'd0;
  localparam logic [1:0] PH_QUOTE   = 2'd1;
  localparam logic [1:0] PH_COLLECT = 2'd2;

  logic [1:0]       phase_q, phase_d;
  logic [1:0]       hpos_q, hpos_d;
  logic [1:0]       spos_q, spos_d;
  logic             dq_q, dq_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             full_q, full_d;

  logic       accept;
  logic [7:0] c;
  logic [7:0] f;
  logic [7:0] quote;
  logic [LINK_NUM_W-1:0] num;

  assign req_i.ready = !q_full_i;
  assign accept      = req_i.valid && req_i.ready;
  assign c           = req_i.byte_in;
  assign f           = fold(c);
  assign quote       = dq_q ? CH_DQUOTE : CH_SQUOTE;
  assign num         = LINK_NUM_W'(32'(cnt_q));

  always_comb begin
    phase_d = phase_q;
    hpos_d  = hpos_q;
    spos_d  = spos_q;
    dq_d    = dq_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    full_d  = full_q;
    push_o  = 1'b0;
    res_o.link_char   = 8'h00;
    res_o.kind        = KIND_CHAR;
    res_o.link_number = num;
    res_o.list_full   = 1'b0;

    if (accept) begin
      if (req_i.end_of_file) begin
        if (!full_q && phase_q == PH_COLLECT) begin
          push_o     = 1'b1;
          res_o.kind = KIND_DISCARD;
        end
        phase_d = PH_SEARCH;
        hpos_d  = 2'd0;
        spos_d  = 2'd0;
        dq_d    = 1'b0;
        len_d   = '0;
        cnt_d   = '0;
        full_d  = 1'b0;
      end else if (full_q) begin
        // list complete, bytes ignored until end of file
      end else if (phase_q == PH_QUOTE) begin
        if (c == CH_SQUOTE) begin
          dq_d    = 1'b0;
          phase_d = PH_COLLECT;
        end else if (c == CH_DQUOTE) begin
          dq_d    = 1'b1;
          phase_d = PH_COLLECT;
        end
      end else if (phase_q == PH_COLLECT) begin
        push_o = 1'b1;
        if (c == CH_HASH || c == quote) begin
          len_d      = '0;
          cnt_d      = cnt_q + CNT_W'(1);
          phase_d    = PH_SEARCH;
          res_o.kind = KIND_DONE;
          if (cnt_q >= CNT_W'(MAX_LINKS - 2)) begin
            full_d          = 1'b1;
            res_o.list_full = 1'b1;
          end
        end else if (len_q >= LEN_W'(LINK_BUFFER - 1)) begin
          res_o.kind = KIND_DROP;
        end else begin
          len_d           = len_q + LEN_W'(1);
          res_o.link_char = c;
        end
      end else begin
        // search for href or src
        if (hpos_q == 2'd0 && spos_q == 2'd0) begin
          if (f == word_h(2'd0)) begin
            hpos_d = 2'd1;
          end else if (f == word_s(2'd0)) begin
            spos_d = 2'd1;
          end
        end else if (hpos_q != 2'd0) begin
          if (f == word_h(hpos_q)) begin
            if (hpos_q == 2'd3) begin
              hpos_d  = 2'd0;
              spos_d  = 2'd0;
              phase_d = PH_QUOTE;
            end else begin
              hpos_d = hpos_q + 2'd1;
            end
          end else begin
            hpos_d = 2'd0;
          end
        end else begin
          if (spos_q < 2'd3 && f == word_s(spos_q)) begin
            if (spos_q == 2'd2) begin
              hpos_d  = 2'd0;
              spos_d  = 2'd0;
              phase_d = PH_QUOTE;
            end else begin
              spos_d = spos_q + 2'd1;
            end
          end else begin
            spos_d = 2'd0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SEARCH;
      hpos_q  <= 2'd0;
      spos_q  <= 2'd0;
      dq_q    <= 1'b0;
      len_q   <= '0;
      cnt_q   <= '0;
      full_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      hpos_q  <= hpos_d;
      spos_q  <= spos_d;
      dq_q    <= dq_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      full_q  <= full_d;
    end
  end

endmodule

`default_nettype wire

// File: src/hlae_queue.sv
// ----------------------------------------------------------------------------
// hlae_queue
// two-entry result queue driving the result channel
// ----------------------------------------------------------------------------
`default_nettype none

module hlae_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire hlae_pkg::result_t res_i,
  output logic                   full_o,
  hlae_out_if.source             res_o
);
  import hlae_pkg::*;

  result_t    mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;
  result_t    head;

  assign head              = mem_q[rd_ptr_q];
  assign res_o.valid       = cnt_q != 2'd0;
  assign res_o.link_char   = head.link_char;
  assign res_o.kind        = head.kind;
  assign res_o.link_number = head.link_number;
  assign res_o.list_full   = head.list_full;
  assign full_o            = cnt_q == 2'd2;
  assign pop               = res_o.valid && res_o.ready;

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    case ({push_i, pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// File: src/html_link_attribute_extractor_unit.sv
// ----------------------------------------------------------------------------
// html_link_attribute_extractor_unit
// extracts the text of href and src attribute values from a byte stream
// ----------------------------------------------------------------------------
// Takes one document byte per cycle and gives at most one result per byte:
// a link character, a link complete mark, a drop mark for bytes past the
// length limit, or a discard mark when end of file cuts an open link. The
// front stage updates the match state in the cycle a byte is accepted and
// writes any result into a two-entry queue whose head drives the result
// channel; each result is registered there and waits behind older ones.
// Requests are taken every cycle as long as the queue is not holding two
// undelivered results; that queue depth is what sets how long the output
// may stall before input stops. No clearing pass follows reset.
`default_nettype none
`include "html_link_attribute_extractor_unit_macros.svh"

module html_link_attribute_extractor_unit (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  hlae_in_if.sink    req_i,
  hlae_out_if.source res_o
);
  import hlae_pkg::*;

  logic    push;
  logic    q_full;
  result_t res;

  hlae_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_i),
    .q_full_i (q_full),
    .push_o   (push),
    .res_o    (res)
  );

  hlae_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .res_i  (res),
    .full_o (q_full),
    .res_o  (res_o)
  );

  `HLAE_ASSERT_SAME(a_no_push_when_full, push, !q_full, "result pushed into full queue")
  `HLAE_ASSERT_NEXT(a_push_shows, push, res_o.valid, "pushed result not presented")
  `HLAE_ASSERT_SAME(a_full_on_done, res_o.valid && res_o.list_full, res_o.kind == KIND_DONE, "list_full on a result that is not a completion")
  `HLAE_ASSERT_SAME(a_char_zero, res_o.valid && res_o.kind != KIND_CHAR, res_o.link_char == 8'h00, "nonzero link_char on a mark")

endmodule

`default_nettype wire
